// File: src/mcsw_pkg.sv
// Shared types and constants for the Stoer-Wagner minimum cut unit.
`timescale 1ns / 1ps
`default_nettype none
package mcsw_pkg;
  localparam int MAX_V      = 64;
  localparam int VIDX_W     = 6;
  localparam int VCNT_W     = 7;
  localparam int WEIGHT_W   = 16;
  localparam int KEY_W      = 32;
  localparam int MAT_ADDR_W = 2 * VIDX_W;
  localparam int MAT_DEPTH  = MAX_V * MAX_V;

  localparam logic [VCNT_W-1:0] MAX_V_CNT = VCNT_W'(MAX_V);
  localparam logic [KEY_W-1:0]  KEY_ONES  = '1;

  localparam logic [1:0] REG_VERTEX_COUNT = 2'd0;
  localparam logic [1:0] REG_START_VERTEX = 2'd1;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_RUN  = 1'b1;

  typedef enum logic [1:0] {
    ALU_NONE,
    ALU_KEY_CMP,
    ALU_SUM,
    ALU_BEST_CMP
  } alu_op_t;

  typedef struct packed {
    logic [KEY_W-1:0] sum;
    logic             gt;
  } alu_res_t;
endpackage
`default_nettype wire

// File: src/min_cut_stoer_wagner_unit.sv
// Top level of the Stoer-Wagner global minimum cut unit.
//
// A load request writes one edge into a 64 by 64 weight matrix held in RAM:
// it reads the pair's entry, then writes both halves when the entry is zero,
// stops after the read when the pair already holds a weight, and is dropped
// without any access when its endpoints or weight make it ignored. A run request
// executes min(vertex_count, 64) - 1 maximum-adjacency phases (none below two
// vertices) on one shared saturating adder and comparator: every phase seeds the
// keys, runs a select sweep and an update sweep per added vertex, and then merges
// the last two vertices, each sweep going through the single read port of each RAM.
// After reset and after every run a clearing pass writes zero to all 4096
// matrix entries, one per cycle, during which no request is taken.
`timescale 1ns / 1ps
`default_nettype none
module min_cut_stoer_wagner_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [6:0]  cfg_data,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,  // node_u[6:0], node_v[13:7], edge_weight[29:14]
  input  wire logic        in_tuser,  // func
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata, // cut_weight[31:0]
  output logic             out_tuser  // no_cut
);
  import mcsw_pkg::*;

  typedef enum logic [20:0] {
    S_IDLE    = 21'd1,
    S_CLEAR   = 21'd2,
    S_LD_RD   = 21'd4,
    S_LD_CHK  = 21'd8,
    S_LD_WR2  = 21'd16,
    S_IN_RD   = 21'd32,
    S_IN_WR   = 21'd64,
    S_SEL_RD  = 21'd128,
    S_SEL_CMP = 21'd256,
    S_SEL_END = 21'd512,
    S_UPD_RD  = 21'd1024,
    S_UPD_WR  = 21'd2048,
    S_MG_RS   = 21'd4096,
    S_MG_RT   = 21'd8192,
    S_MG_W1   = 21'd16384,
    S_MG_W2   = 21'd32768,
    S_MG_W3   = 21'd65536,
    S_MG_W4   = 21'd131072,
    S_MG_F1   = 21'd262144,
    S_MG_F2   = 21'd524288,
    S_DONE    = 21'd1048576
  } state_t;

  state_t                state_r, state_nxt;
  logic [VCNT_W-1:0]     vcount_r, vcount_nxt;
  logic [VIDX_W-1:0]     start_r, start_nxt;
  logic [VCNT_W-1:0]     x_r, x_nxt;
  logic [VIDX_W-1:0]     u_r, u_nxt, v_r, v_nxt;
  logic [WEIGHT_W-1:0]   w_r, w_nxt;
  logic [MAT_ADDR_W-1:0] clr_r, clr_nxt;
  logic [VCNT_W-1:0]     n_r, n_nxt;
  logic [VIDX_W-1:0]     st_r, st_nxt;
  logic [VCNT_W-1:0]     live_r, live_nxt;
  logic [VCNT_W-1:0]     added_r, added_nxt;
  logic                  found_r, found_nxt;
  logic [VIDX_W-1:0]     pick_r, pick_nxt;
  logic [KEY_W-1:0]      bestk_r, bestk_nxt;
  logic [VIDX_W-1:0]     prev_r, prev_nxt, last_r, last_nxt;
  logic [KEY_W-1:0]      cut_r, cut_nxt;
  logic [KEY_W-1:0]      best_r, best_nxt;
  logic [KEY_W-1:0]      tmp_r, tmp_nxt;
  logic [MAX_V-1:0]      active_r, active_nxt;
  logic [MAX_V-1:0]      inset_r, inset_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [KEY_W-1:0]      out_data_r, out_data_nxt;
  logic                  out_nocut_r, out_nocut_nxt;

  logic                  mat_we;
  logic [MAT_ADDR_W-1:0] mat_waddr, mat_raddr;
  logic [KEY_W-1:0]      mat_wdata, mat_rdata;
  logic                  key_we;
  logic [VIDX_W-1:0]     key_waddr, key_raddr;
  logic [KEY_W-1:0]      key_wdata, key_rdata;

  alu_op_t               alu_op;
  logic [KEY_W-1:0]      alu_a, alu_b;
  alu_res_t              alu_res;

  logic [VCNT_W-1:0]     used_n;
  logic [VCNT_W-1:0]     in_u, in_v;
  logic [WEIGHT_W-1:0]   in_w;
  logic                  in_acc, load_ok, out_free;
  logic [VIDX_W-1:0]     xi;

  mcsw_ram #(.WIDTH(KEY_W), .DEPTH(MAT_DEPTH)) u_mat (
    .clk(clk), .we(mat_we), .waddr(mat_waddr), .wdata(mat_wdata),
    .raddr(mat_raddr), .rdata(mat_rdata)
  );

  mcsw_ram #(.WIDTH(KEY_W), .DEPTH(MAX_V)) u_key (
    .clk(clk), .we(key_we), .waddr(key_waddr), .wdata(key_wdata),
    .raddr(key_raddr), .rdata(key_rdata)
  );

  mcsw_alu u_alu (.a(alu_a), .b(alu_b), .res(alu_res));

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_nocut_r;

  always_comb begin
    alu_a = '0;
    alu_b = '0;
    unique case (alu_op)
      ALU_KEY_CMP: begin
        alu_a = key_rdata;
        alu_b = bestk_r;
      end
      ALU_SUM: begin
        alu_a = (state_r == S_MG_W1) ? tmp_r : key_rdata;
        alu_b = mat_rdata;
      end
      ALU_BEST_CMP: begin
        alu_a = best_r;
        alu_b = cut_r;
      end
      default: begin
        alu_a = '0;
        alu_b = '0;
      end
    endcase
  end

  always_comb begin
    used_n   = (vcount_r > MAX_V_CNT) ? MAX_V_CNT : vcount_r;
    in_u     = in_tdata[6:0];
    in_v     = in_tdata[13:7];
    in_w     = in_tdata[29:14];
    in_acc   = in_tvalid && in_tready;
    load_ok  = (in_u != '0) && (in_v != '0) && (in_u <= used_n) && (in_v <= used_n) &&
               (in_u != in_v) && (in_w != '0);
    out_free = !out_valid_r || out_tready;
    xi       = x_r[VIDX_W-1:0];

    state_nxt     = state_r;
    vcount_nxt    = vcount_r;
    start_nxt     = start_r;
    x_nxt         = x_r;
    u_nxt         = u_r;
    v_nxt         = v_r;
    w_nxt         = w_r;
    clr_nxt       = clr_r;
    n_nxt         = n_r;
    st_nxt        = st_r;
    live_nxt      = live_r;
    added_nxt     = added_r;
    found_nxt     = found_r;
    pick_nxt      = pick_r;
    bestk_nxt     = bestk_r;
    prev_nxt      = prev_r;
    last_nxt      = last_r;
    cut_nxt       = cut_r;
    best_nxt      = best_r;
    tmp_nxt       = tmp_r;
    active_nxt    = active_r;
    inset_nxt     = inset_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_nocut_nxt = out_nocut_r;

    mat_we    = 1'b0;
    mat_waddr = '0;
    mat_wdata = '0;
    mat_raddr = '0;
    key_we    = 1'b0;
    key_waddr = xi;
    key_wdata = '0;
    key_raddr = xi;
    alu_op    = ALU_NONE;

    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_VERTEX_COUNT: vcount_nxt = cfg_data;
        REG_START_VERTEX: start_nxt  = cfg_data[VIDX_W-1:0];
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_tuser == FUNC_LOAD) begin
            if (load_ok) begin
              u_nxt     = VIDX_W'(in_u - 7'd1);
              v_nxt     = VIDX_W'(in_v - 7'd1);
              w_nxt     = in_w;
              state_nxt = S_LD_RD;
            end
          end else begin
            n_nxt      = used_n;
            st_nxt     = (VCNT_W'(start_r) < used_n) ? start_r : '0;
            best_nxt   = KEY_ONES;
            active_nxt = '1;
            live_nxt   = used_n;
            x_nxt      = '0;
            state_nxt  = (used_n < 7'd2) ? S_DONE : S_IN_RD;
          end
        end
      end
      S_CLEAR: begin
        mat_we     = 1'b1;
        mat_waddr  = clr_r;
        mat_wdata  = '0;
        active_nxt = '1;
        inset_nxt  = '0;
        clr_nxt    = clr_r + 1'b1;
        if (clr_r == '1) begin
          state_nxt = S_IDLE;
        end
      end
      S_LD_RD: begin
        mat_raddr = {u_r, v_r};
        state_nxt = S_LD_CHK;
      end
      S_LD_CHK: begin
        if (mat_rdata == '0) begin
          mat_we    = 1'b1;
          mat_waddr = {u_r, v_r};
          mat_wdata = KEY_W'(w_r);
          state_nxt = S_LD_WR2;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_LD_WR2: begin
        mat_we    = 1'b1;
        mat_waddr = {v_r, u_r};
        mat_wdata = KEY_W'(w_r);
        state_nxt = S_IDLE;
      end
      S_IN_RD: begin
        if (x_r == n_r) begin
          inset_nxt         = '0;
          inset_nxt[st_r]   = 1'b1;
          prev_nxt          = st_r;
          last_nxt          = st_r;
          cut_nxt           = '0;
          added_nxt         = 7'd1;
          x_nxt             = '0;
          found_nxt         = 1'b0;
          state_nxt         = S_SEL_RD;
        end else begin
          mat_raddr = {st_r, xi};
          state_nxt = S_IN_WR;
        end
      end
      S_IN_WR: begin
        key_we    = 1'b1;
        key_wdata = mat_rdata;
        x_nxt     = x_r + 1'b1;
        state_nxt = S_IN_RD;
      end
      S_SEL_RD: begin
        if (x_r == n_r) begin
          state_nxt = S_SEL_END;
        end else begin
          state_nxt = S_SEL_CMP;
        end
      end
      S_SEL_CMP: begin
        alu_op = ALU_KEY_CMP;
        if (active_r[xi] && !inset_r[xi] && (!found_r || alu_res.gt)) begin
          found_nxt = 1'b1;
          pick_nxt  = xi;
          bestk_nxt = key_rdata;
        end
        x_nxt     = x_r + 1'b1;
        state_nxt = S_SEL_RD;
      end
      S_SEL_END: begin
        x_nxt = '0;
        if (!found_r) begin
          state_nxt = S_MG_RS;
        end else begin
          prev_nxt          = last_r;
          last_nxt          = pick_r;
          cut_nxt           = bestk_r;
          inset_nxt[pick_r] = 1'b1;
          state_nxt         = S_UPD_RD;
        end
      end
      S_UPD_RD: begin
        if (x_r == n_r) begin
          x_nxt     = '0;
          added_nxt = added_r + 1'b1;
          found_nxt = 1'b0;
          state_nxt = ((added_r + 1'b1) == live_r) ? S_MG_RS : S_SEL_RD;
        end else begin
          mat_raddr = {pick_r, xi};
          state_nxt = S_UPD_WR;
        end
      end
      S_UPD_WR: begin
        alu_op = ALU_SUM;
        if (active_r[xi] && !inset_r[xi]) begin
          key_we    = 1'b1;
          key_wdata = alu_res.sum;
        end
        x_nxt     = x_r + 1'b1;
        state_nxt = S_UPD_RD;
      end
      S_MG_RS: begin
        if (x_r == n_r) begin
          state_nxt = S_MG_F1;
        end else if (xi == prev_r || xi == last_r) begin
          x_nxt = x_r + 1'b1;
        end else begin
          mat_raddr = {prev_r, xi};
          state_nxt = S_MG_RT;
        end
      end
      S_MG_RT: begin
        mat_raddr = {last_r, xi};
        tmp_nxt   = mat_rdata;
        state_nxt = S_MG_W1;
      end
      S_MG_W1: begin
        alu_op    = ALU_SUM;
        mat_we    = 1'b1;
        mat_waddr = {prev_r, xi};
        mat_wdata = alu_res.sum;
        tmp_nxt   = alu_res.sum;
        state_nxt = S_MG_W2;
      end
      S_MG_W2: begin
        mat_we    = 1'b1;
        mat_waddr = {xi, prev_r};
        mat_wdata = tmp_r;
        state_nxt = S_MG_W3;
      end
      S_MG_W3: begin
        mat_we    = 1'b1;
        mat_waddr = {last_r, xi};
        state_nxt = S_MG_W4;
      end
      S_MG_W4: begin
        mat_we    = 1'b1;
        mat_waddr = {xi, last_r};
        x_nxt     = x_r + 1'b1;
        state_nxt = S_MG_RS;
      end
      S_MG_F1: begin
        mat_we    = 1'b1;
        mat_waddr = {prev_r, last_r};
        state_nxt = S_MG_F2;
      end
      S_MG_F2: begin
        mat_we             = 1'b1;
        mat_waddr          = {last_r, prev_r};
        active_nxt[last_r] = 1'b0;
        alu_op             = ALU_BEST_CMP;
        if (alu_res.gt) begin
          best_nxt = cut_r;
        end
        live_nxt  = live_r - 1'b1;
        x_nxt     = '0;
        state_nxt = (live_r == 7'd2) ? S_DONE : S_IN_RD;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (n_r < 7'd2) begin
            out_data_nxt  = KEY_ONES;
            out_nocut_nxt = 1'b1;
          end else begin
            out_data_nxt  = best_r;
            out_nocut_nxt = 1'b0;
          end
          clr_nxt   = '0;
          state_nxt = S_CLEAR;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      vcount_r    <= MAX_V_CNT;
      start_r     <= '0;
      out_valid_r <= 1'b0;
      active_r    <= '1;
      inset_r     <= '0;
      best_r      <= KEY_ONES;
      prev_r      <= '0;
      last_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      vcount_r    <= vcount_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
      active_r    <= active_nxt;
      inset_r     <= inset_nxt;
      best_r      <= best_nxt;
      prev_r      <= prev_nxt;
      last_r      <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r         <= x_nxt;
    u_r         <= u_nxt;
    v_r         <= v_nxt;
    w_r         <= w_nxt;
    n_r         <= n_nxt;
    st_r        <= st_nxt;
    live_r      <= live_nxt;
    added_r     <= added_nxt;
    found_r     <= found_nxt;
    pick_r      <= pick_nxt;
    bestk_r     <= bestk_nxt;
    cut_r       <= cut_nxt;
    tmp_r       <= tmp_nxt;
    out_data_r  <= out_data_nxt;
    out_nocut_r <= out_nocut_nxt;
  end
endmodule
`default_nettype wire

// File: src/mcsw_ram.sv
// Generic simple dual-port RAM with a registered read.
`timescale 1ns / 1ps
`default_nettype none
module mcsw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: src/mcsw_alu.sv
// Shared saturating adder and magnitude comparator.
`timescale 1ns / 1ps
`default_nettype none
module mcsw_alu (
  input  wire logic [mcsw_pkg::KEY_W-1:0] a,
  input  wire logic [mcsw_pkg::KEY_W-1:0] b,
  output mcsw_pkg::alu_res_t              res
);
  import mcsw_pkg::*;

  logic [KEY_W:0] full;

  always_comb begin
    full    = {1'b0, a} + {1'b0, b};
    res.sum = full[KEY_W] ? KEY_ONES : full[KEY_W-1:0];
    res.gt  = (a > b);
  end
endmodule
`default_nettype wire

// File: src/mcsw_checker.sv
// Port-level checker for the minimum cut unit and its bind statement.
`timescale 1ns / 1ps
`default_nettype none
module mcsw_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        in_tuser,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata,
  input wire logic        out_tuser
);
  a_nocut_ones: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == 32'hFFFF_FFFF)
    else $error("no-cut result without all-ones weight");

  a_busy_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser |=> !in_tready)
    else $error("request accepted while a run is still in work");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !in_tready)
    else $error("activity right after reset");
endmodule

bind min_cut_stoer_wagner_unit mcsw_checker u_mcsw_checker (.*);
`default_nettype wire

// File: test/testbench.sv
// Self-checking testbench for the Stoer-Wagner global minimum cut unit.
`timescale 1ns / 1ps
module testbench;
  import mcsw_pkg::*;

  typedef struct {
    logic       func;
    logic [6:0] node_u;
    logic [6:0] node_v;
    logic [15:0] weight;
  } edge_req_t;

  typedef struct {
    logic [31:0] cut_weight;
    logic        no_cut;
  } cut_result_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [6:0]  cfg_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic        out_tuser;

  edge_req_t   pending_reqs[$];
  cut_result_t expected_cuts[$];
  logic        in_taken;
  int          in_idle_pct;
  int          out_idle_pct;
  int          hold_cycles;
  int          errors;
  int          cycle_count;
  int          sent_items;

  logic [31:0] graph[MAX_V][MAX_V];
  logic        alive[MAX_V];
  logic        grown[MAX_V];
  logic [31:0] gain[MAX_V];
  int          model_vcount;
  int          model_start;

  min_cut_stoer_wagner_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [31:0] sat_sum(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? KEY_ONES : s[31:0];
  endfunction

  task automatic clear_graph();
    for (int i = 0; i < MAX_V; i++) begin
      alive[i] = 1'b1;
      grown[i] = 1'b0;
      for (int j = 0; j < MAX_V; j++) graph[i][j] = '0;
    end
  endtask

  task automatic min_cut_phase(int n, int st, int live, output logic [31:0] cut);
    int pick;
    int s;
    int t;
    logic [31:0] w;
    cut = '0;
    for (int x = 0; x < n; x++) begin
      grown[x] = 1'b0;
      gain[x] = graph[st][x];
    end
    grown[st] = 1'b1;
    s = st;
    t = st;
    for (int added = 1; added < live; added++) begin
      pick = n;
      for (int x = 0; x < n; x++)
        if (alive[x] && !grown[x] && (pick == n || gain[x] > gain[pick])) pick = x;
      if (pick == n) break;
      s = t;
      t = pick;
      cut = gain[pick];
      grown[pick] = 1'b1;
      for (int x = 0; x < n; x++)
        if (alive[x] && !grown[x]) gain[x] = sat_sum(gain[x], graph[pick][x]);
    end
    for (int x = 0; x < n; x++) begin
      if (x != s && x != t) begin
        w = sat_sum(graph[s][x], graph[t][x]);
        graph[s][x] = w;
        graph[x][s] = w;
        graph[t][x] = '0;
        graph[x][t] = '0;
      end
    end
    graph[s][t] = '0;
    graph[t][s] = '0;
    alive[t] = 1'b0;
  endtask

  task automatic predict_cut(edge_req_t r);
    int n;
    int u;
    int v;
    int st;
    logic [31:0] c;
    cut_result_t res;
    n = (model_vcount > MAX_V) ? MAX_V : model_vcount;
    if (r.func == FUNC_LOAD) begin
      u = r.node_u;
      v = r.node_v;
      if (u == 0 || v == 0 || u > n || v > n || u == v || r.weight == 0) return;
      u--;
      v--;
      if (graph[u][v] != 0 || graph[v][u] != 0) return;
      graph[u][v] = {16'b0, r.weight};
      graph[v][u] = {16'b0, r.weight};
      return;
    end
    st = (model_start < n) ? model_start : 0;
    for (int x = 0; x < MAX_V; x++) alive[x] = 1'b1;
    res.cut_weight = KEY_ONES;
    res.no_cut = 1'b1;
    if (n >= 2) begin
      res.no_cut = 1'b0;
      for (int live = n; live > 1; live--) begin
        min_cut_phase(n, st, live, c);
        if (c < res.cut_weight) res.cut_weight = c;
      end
    end
    expected_cuts = {expected_cuts, res};
    clear_graph();
  endtask

  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_taken) begin
      if (pending_reqs.size() > 0 && $urandom_range(99) >= in_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tdata  <= {2'b00, pending_reqs[0].weight, pending_reqs[0].node_v,
                      pending_reqs[0].node_u};
        in_tuser  <= pending_reqs[0].func;
        void'(pending_reqs.pop_front());
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles = hold_cycles - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  always @(posedge clk) begin
    edge_req_t   r;
    cut_result_t e;
    in_taken <= in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      r.func   = in_tuser;
      r.node_u = in_tdata[6:0];
      r.node_v = in_tdata[13:7];
      r.weight = in_tdata[29:14];
      predict_cut(r);
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_cuts.size() == 0) begin
        $display("%0t: unexpected result cut_weight=%h no_cut=%b", $realtime,
                 out_tdata, out_tuser);
        errors++;
      end else begin
        e = expected_cuts.pop_front();
        if (out_tdata !== e.cut_weight) begin
          $display("%0t: cut_weight expected %h actual %h", $realtime,
                   e.cut_weight, out_tdata);
          errors++;
        end
        if (out_tuser !== e.no_cut) begin
          $display("%0t: no_cut expected %b actual %b", $realtime, e.no_cut,
                   out_tuser);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > 6000000) begin
      $display("** min_cut_stoer_wagner_unit: FAILED **");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, int value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[6:0];
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_VERTEX_COUNT) model_vcount = value;
    else model_start = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || in_tvalid || expected_cuts.size() > 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic push_req(logic func, int u, int v, int w);
    edge_req_t r;
    r.func = func;
    r.node_u = u[6:0];
    r.node_v = v[6:0];
    r.weight = w[15:0];
    pending_reqs = {pending_reqs, r};
    sent_items++;
  endtask

  task automatic push_graph(int n, int loads);
    int u;
    int v;
    int w;
    for (int i = 0; i < loads; i++) begin
      u = $urandom_range(1, n > 0 ? n : 1);
      v = $urandom_range(1, n > 0 ? n : 1);
      case ($urandom_range(9))
        0: u = $urandom_range(127);
        1: v = $urandom_range(127);
        default: ;
      endcase
      case ($urandom_range(7))
        0: w = 0;
        1: w = 16'hFFFF;
        2: w = $urandom_range(1, 3);
        default: w = $urandom_range(65535);
      endcase
      push_req(FUNC_LOAD, u, v, w);
    end
    push_req(FUNC_RUN, $urandom_range(127), $urandom_range(127), $urandom_range(65535));
  endtask

  initial begin
    int n;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    out_tready = 1'b0;
    in_taken = 1'b0;
    in_idle_pct = 0;
    out_idle_pct = 0;
    hold_cycles = 0;
    errors = 0;
    cycle_count = 0;
    sent_items = 0;
    model_vcount = 64;
    model_start = 0;
    clear_graph();
    for (int i = 0; i < MAX_V; i++) gain[i] = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Full-size graph loads, then a smaller count leaves stale edges behind.
    push_req(FUNC_LOAD, 64, 1, 16'hFFFF);
    push_req(FUNC_LOAD, 1, 64, 5);
    push_req(FUNC_LOAD, 2, 2, 7);
    push_req(FUNC_LOAD, 0, 3, 7);
    push_req(FUNC_LOAD, 3, 65, 7);
    push_req(FUNC_LOAD, 127, 127, 16'hFFFF);
    push_req(FUNC_LOAD, 1, 2, 0);
    push_req(FUNC_LOAD, 1, 2, 16'hFFFF);
    push_req(FUNC_LOAD, 2, 1, 9);
    push_req(FUNC_LOAD, 3, 4, 1);
    wait_drained();
    write_reg(REG_VERTEX_COUNT, 4);
    write_reg(REG_START_VERTEX, 3);
    push_req(FUNC_LOAD, 2, 3, 16'h8000);
    push_req(FUNC_RUN, 127, 127, 16'hFFFF);
    wait_drained();
    write_reg(REG_START_VERTEX, 63);
    push_req(FUNC_LOAD, 1, 2, 4);
    push_req(FUNC_LOAD, 3, 4, 4);
    push_req(FUNC_RUN, 0, 0, 0);
    wait_drained();
    write_reg(REG_VERTEX_COUNT, 0);
    push_req(FUNC_LOAD, 1, 2, 4);
    push_req(FUNC_RUN, 0, 0, 0);
    wait_drained();
    write_reg(REG_VERTEX_COUNT, 1);
    write_reg(REG_START_VERTEX, 0);
    push_req(FUNC_RUN, 0, 0, 0);
    wait_drained();
    write_reg(REG_VERTEX_COUNT, 2);
    push_req(FUNC_LOAD, 2, 1, 16'hFFFF);
    push_req(FUNC_RUN, 0, 0, 0);
    wait_drained();

    // Receiver held off while the sender keeps offering requests.
    write_reg(REG_VERTEX_COUNT, 5);
    hold_cycles = 20000;
    push_graph(5, 12);
    push_graph(5, 12);
    push_graph(5, 12);
    wait_drained();

    for (int k = 0; sent_items < 1750; k++) begin
      case (k % 4)
        0: begin in_idle_pct = 0;  out_idle_pct = 0;  end
        1: begin in_idle_pct = 72; out_idle_pct = 0;  end
        2: begin in_idle_pct = 0;  out_idle_pct = 72; end
        default: begin in_idle_pct = 17; out_idle_pct = 17; end
      endcase
      case ($urandom_range(19))
        0: n = $urandom_range(1);
        1: n = $urandom_range(10, 14);
        2: n = 64;
        default: n = $urandom_range(2, 8);
      endcase
      write_reg(REG_VERTEX_COUNT, n);
      write_reg(REG_START_VERTEX, $urandom_range(3) == 0 ? $urandom_range(63)
                                                         : $urandom_range(n > 0 ? n - 1 : 0));
      if (n == 64) begin
        push_graph(64, 20);
        void'(pending_reqs.pop_back());
        sent_items--;
      end else begin
        push_graph(n, $urandom_range(5, 35));
        if ($urandom_range(3) == 0) push_graph(n, $urandom_range(2, 10));
      end
      wait_drained();
    end

    while (expected_cuts.size() > 0) @(posedge clk);
    repeat (4200) @(posedge clk);
    if (errors == 0) begin
      $display("** min_cut_stoer_wagner_unit: PASSED **");
    end else begin
      $display("** min_cut_stoer_wagner_unit: FAILED **");
    end
    $finish;
  end
endmodule
